// File: design/psrf_pkg.sv
// Shared types and codes for the packet slot ring FIFO.
// Holds the input and result transaction structs, function and status codes,
// and the configuration register indexes. No dependencies.
package psrf_pkg;

  localparam int FUNC_W      = 2;
  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 7;
  localparam int STATUS_W    = 3;
  localparam int OCC_W       = 4;
  localparam int SLOTS_CFG_W = 5;
  localparam int CFG_DATA_W  = 7;
  localparam int CFG_INDEX_W = 1;

  // Function codes of an input transaction
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd3;

  // Status codes of a result transaction
  localparam logic [STATUS_W-1:0] ST_BYTE_TAKEN = 3'd0;
  localparam logic [STATUS_W-1:0] ST_COMMITTED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_LENGTH = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd3;
  localparam logic [STATUS_W-1:0] ST_READ_BYTE  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd5;
  localparam logic [STATUS_W-1:0] ST_SKIPPED    = 3'd6;
  localparam logic [STATUS_W-1:0] ST_ACK        = 3'd7;

  // Configuration register indexes and reset values
  localparam logic [CFG_INDEX_W-1:0] REG_SLOTS_IN_USE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_BYTES    = 1'd1;
  localparam logic [SLOTS_CFG_W-1:0] SLOTS_IN_USE_RST = 5'd16;
  localparam logic [LEN_W-1:0]       MAX_BYTES_RST    = 7'd64;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [BYTE_W-1:0] data_byte;
    logic              last;
    logic [LEN_W-1:0]  max_length;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   data_out;
    logic [LEN_W-1:0]    packet_length;
    logic                last_out;
    logic [OCC_W-1:0]    occupancy;
  } out_item_t;

endpackage

// File: design/psrf_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port.
// Read data is registered and holds while no read is issued. No dependencies.
module psrf_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/packet_slot_ring_fifo_top.sv
// Packet slot ring FIFO: controller, index registers and result register.
// Depends on psrf_pkg and on psrf_ram for the packet byte and slot length stores.
//
//   channel  | direction | handshake           | payload
//   in       | input     | in_valid / in_stall   | psrf_pkg::in_item_t
//   out      | output    | out_valid / out_stall | psrf_pkg::out_item_t
//   cfg      | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Write, clear and query transactions are taken one per cycle while no read is in
// progress and the result register is empty or being drained.
// A read first fetches the slot length, decides in S_LEN whether to skip the packet,
// then gives one byte per cycle, unless the output stalls, from the packet RAM, whose
// read data register acts as a holding stage; no input is taken until the read ends.
// Reset (synchronous) clears both slot indices and the partial packet; the RAMs
// need no clearing pass. Output stalls freeze the byte stream without loss.
module packet_slot_ring_fifo_top #(
  parameter int SLOTS      = 16,
  parameter int SLOT_BYTES = 64
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  psrf_pkg::in_item_t                      in_item,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output psrf_pkg::out_item_t                     out_item,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [psrf_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [psrf_pkg::CFG_DATA_W-1:0]         cfg_data
);

  import psrf_pkg::*;

  localparam int SW    = $clog2(SLOTS);
  localparam int NW    = (SW + 1 > SLOTS_CFG_W) ? SW + 1 : SLOTS_CFG_W;
  localparam int BW    = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
  localparam int DEPTH = SLOTS * SLOT_BYTES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [LEN_W-1:0] LEN_ONE   = LEN_W'(1);
  localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(SLOT_BYTES);
  localparam logic [NW-1:0]    NSLOTS    = NW'(SLOTS);
  localparam logic [NW-1:0]    NTWO      = NW'(2);
  localparam logic [NW-1:0]    NONE      = NW'(1);
  localparam logic [AW-1:0]    ASTRIDE   = AW'(SLOT_BYTES);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_LEN    = 3'b010,
    S_STREAM = 3'b100
  } state_t;

  state_t state, state_next;

  logic [SW-1:0]          write_slot, write_slot_next;
  logic [SW-1:0]          read_slot, read_slot_next;
  logic [LEN_W-1:0]       bytes_gathered, bytes_gathered_next;
  logic                   oversize_seen, oversize_seen_next;
  logic [SLOTS_CFG_W-1:0] slots_in_use;
  logic [LEN_W-1:0]       max_bytes_per_slot;
  logic [SW-1:0]          base_slot, base_slot_next;
  logic [LEN_W-1:0]       cap, cap_next;
  logic [LEN_W-1:0]       len_q, len_q_next;
  logic [LEN_W-1:0]       idx, idx_next;
  logic                   pend, pend_next;
  logic                   pend_last, pend_last_next;

  logic                   load_out;
  out_item_t              out_next;
  logic                   out_free;
  logic                   accept;
  logic                   slots_write;

  logic [NW-1:0]          eff_slots;
  logic [LEN_W-1:0]       limit;
  logic [NW-1:0]          wr_plus, rd_plus;
  logic [SW-1:0]          wr_adv, rd_adv;
  logic [NW-1:0]          occ;
  logic [LEN_W-1:0]       len_eff;
  logic                   move, issue;

  logic                   byte_we, byte_re;
  logic [AW-1:0]          byte_waddr, byte_raddr;
  logic [BYTE_W-1:0]      byte_rdata;
  logic                   len_we, len_re;
  logic [LEN_W-1:0]       len_wdata;
  logic [LEN_W-1:0]       len_rdata;

  psrf_ram #(.DEPTH(DEPTH), .AW(AW), .WIDTH(BYTE_W)) u_byte_ram (
    .clk   (clk),
    .we    (byte_we),
    .waddr (byte_waddr),
    .wdata (in_item.data_byte),
    .re    (byte_re),
    .raddr (byte_raddr),
    .rdata (byte_rdata)
  );

  psrf_ram #(.DEPTH(SLOTS), .AW(SW), .WIDTH(LEN_W)) u_len_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (write_slot),
    .wdata (len_wdata),
    .re    (len_re),
    .raddr (read_slot),
    .rdata (len_rdata)
  );

  // A commit always stores its last byte in the same cycle
  assign len_wdata = bytes_gathered + LEN_ONE;

  // Clamp the configured values into their legal ranges
  always_comb begin
    if (NW'(slots_in_use) < NTWO) begin
      eff_slots = NTWO;
    end else if (NW'(slots_in_use) > NSLOTS) begin
      eff_slots = NSLOTS;
    end else begin
      eff_slots = NW'(slots_in_use);
    end
    if (max_bytes_per_slot == '0) begin
      limit = LEN_ONE;
    end else if (max_bytes_per_slot > LEN_LIMIT) begin
      limit = LEN_LIMIT;
    end else begin
      limit = max_bytes_per_slot;
    end
  end

  assign wr_plus = NW'(write_slot) + NONE;
  assign rd_plus = NW'(read_slot) + NONE;
  assign wr_adv  = (wr_plus >= eff_slots) ? '0 : wr_plus[SW-1:0];
  assign rd_adv  = (rd_plus >= eff_slots) ? '0 : rd_plus[SW-1:0];

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = !((state == S_IDLE) && out_free);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign slots_write = cfg_valid && cfg_ready && (cfg_index == REG_SLOTS_IN_USE);

  assign len_eff = (len_rdata > LEN_LIMIT) ? LEN_LIMIT : len_rdata;
  assign move    = (state == S_STREAM) && pend && out_free;
  assign issue   = (state == S_STREAM) && (idx < len_q) && (!pend || move);

  assign byte_waddr = AW'(write_slot) * ASTRIDE + AW'(bytes_gathered[BW-1:0]);
  assign byte_raddr = AW'(base_slot) * ASTRIDE + AW'(idx[BW-1:0]);
  assign byte_re    = issue;

  always_comb begin
    state_next          = state;
    write_slot_next     = write_slot;
    read_slot_next      = read_slot;
    bytes_gathered_next = bytes_gathered;
    oversize_seen_next  = oversize_seen;
    base_slot_next      = base_slot;
    cap_next            = cap;
    len_q_next          = len_q;
    idx_next            = idx;
    pend_last_next      = pend_last;
    pend_next           = issue || (pend && !move);
    load_out            = 1'b0;
    out_next            = '0;
    byte_we             = 1'b0;
    len_we              = 1'b0;
    len_re              = 1'b0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          load_out          = 1'b1;
          out_next.last_out = 1'b1;
          case (in_item.func)
            FUNC_WRITE: begin
              if (!oversize_seen && (bytes_gathered < limit)) begin
                byte_we             = 1'b1;
                bytes_gathered_next = bytes_gathered + LEN_ONE;
              end else begin
                oversize_seen_next = 1'b1;
              end
              if (!in_item.last) begin
                out_next.status        = ST_BYTE_TAKEN;
                out_next.packet_length = bytes_gathered_next;
              end else begin
                if (oversize_seen_next) begin
                  out_next.status = ST_BAD_LENGTH;
                end else if (wr_adv == read_slot) begin
                  out_next.status = ST_FULL;
                end else begin
                  len_we                 = 1'b1;
                  write_slot_next        = wr_adv;
                  out_next.status        = ST_COMMITTED;
                  out_next.packet_length = bytes_gathered_next;
                end
                bytes_gathered_next = '0;
                oversize_seen_next  = 1'b0;
              end
            end
            FUNC_READ: begin
              if (read_slot == write_slot) begin
                out_next.status = ST_EMPTY;
              end else begin
                // Fetch the length first; the result comes from S_LEN or S_STREAM
                load_out       = 1'b0;
                len_re         = 1'b1;
                base_slot_next = read_slot;
                cap_next       = in_item.max_length;
                read_slot_next = rd_adv;
                state_next     = S_LEN;
              end
            end
            FUNC_CLEAR: begin
              write_slot_next     = '0;
              read_slot_next      = '0;
              bytes_gathered_next = '0;
              oversize_seen_next  = 1'b0;
              out_next.status     = ST_ACK;
            end
            default: begin
              out_next.status = ST_ACK;
            end
          endcase
        end
      end
      S_LEN: begin
        if ((len_eff > cap) || (len_eff == '0)) begin
          // Drop the packet with a single result
          if (out_free) begin
            load_out          = 1'b1;
            out_next.status   = ST_SKIPPED;
            out_next.last_out = 1'b1;
            state_next        = S_IDLE;
          end
        end else begin
          len_q_next = len_eff;
          idx_next   = '0;
          state_next = S_STREAM;
        end
      end
      S_STREAM: begin
        if (issue) begin
          idx_next       = idx + LEN_ONE;
          pend_last_next = ((idx + LEN_ONE) == len_q);
        end
        if (move) begin
          load_out               = 1'b1;
          out_next.status        = ST_READ_BYTE;
          out_next.data_out      = byte_rdata;
          out_next.packet_length = len_q;
          out_next.last_out      = pend_last;
          if (pend_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    out_next.occupancy = occ[OCC_W-1:0];
  end

  // Occupancy after this step, modulo the slot count
  always_comb begin
    if (write_slot_next >= read_slot_next) begin
      occ = NW'(write_slot_next) - NW'(read_slot_next);
    end else begin
      occ = NW'(write_slot_next) + eff_slots - NW'(read_slot_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      write_slot         <= '0;
      read_slot          <= '0;
      bytes_gathered     <= '0;
      oversize_seen      <= 1'b0;
      slots_in_use       <= SLOTS_IN_USE_RST;
      max_bytes_per_slot <= MAX_BYTES_RST;
      out_valid          <= 1'b0;
      pend               <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
      // Changing the slot count invalidates both indices
      if (slots_write) begin
        write_slot     <= '0;
        read_slot      <= '0;
        bytes_gathered <= '0;
        oversize_seen  <= 1'b0;
      end else begin
        write_slot     <= write_slot_next;
        read_slot      <= read_slot_next;
        bytes_gathered <= bytes_gathered_next;
        oversize_seen  <= oversize_seen_next;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SLOTS_IN_USE: begin
            slots_in_use <= cfg_data[SLOTS_CFG_W-1:0];
          end
          REG_MAX_BYTES: begin
            max_bytes_per_slot <= cfg_data;
          end
          default: begin
            max_bytes_per_slot <= max_bytes_per_slot;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    base_slot <= base_slot_next;
    cap       <= cap_next;
    len_q     <= len_q_next;
    idx       <= idx_next;
    pend_last <= pend_last_next;
    if (load_out) begin
      out_item <= out_next;
    end
  end

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall)
    else $error("input taken while a read is in progress");

  assert property (@(posedge clk) disable iff (rst)
    (NW'(write_slot) < eff_slots) && (NW'(read_slot) < eff_slots))
    else $error("slot index beyond the slot count");

  assert property (@(posedge clk) disable iff (rst)
    pend |-> (state == S_STREAM))
    else $error("packet RAM read pending outside the byte stream");

  assert property (@(posedge clk) disable iff (rst)
    bytes_gathered <= LEN_LIMIT)
    else $error("gathered byte count exceeds the slot size");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_STREAM) |-> (idx <= len_q))
    else $error("byte index ran past the packet length");
`endif

endmodule
